FILE: rtl/fs_pkg.sv
// fs_pkg: port widths and item codes shared by the Fibonacci search block.
// No dependencies.
`timescale 1ns / 1ps

package fs_pkg;

    localparam int SLOT_W    = 10;
    localparam int VALUE_W   = 32;
    localparam int LEN_W     = 11;
    localparam int POS_W     = 10;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1;

endpackage

FILE: rtl/fs_ram.sv
// fs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [AW-1:0]            rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/fibonacci_search.sv
// fibonacci_search: Fibonacci search over a sorted store of signed elements.
// Depends on fs_pkg and fs_ram.
//
//   channel   direction  payload
//   s_*       in         tuser: op; tdata: slot [9:0], value [41:10]
//   m_*       out        tuser: found; tdata: position [9:0]
//   cfg_*     in         data: used_length [10:0]
//
// A write item is handled in the idle state. A search starts, takes Fibonacci
// steps to size the range, runs probes (RAM read, then the shared compare),
// makes a last check if one is due and hands off the result.
// Reset is asynchronous and clears control only; the store is not cleared.
// s_tready is low while a search runs; a finished result waits in the output
// register and a new item is taken meanwhile.
`timescale 1ns / 1ps

module fibonacci_search #(
    parameter int DEPTH         = 1024,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fs_pkg::S_TDATA_W-1:0]  s_tdata,   // slot, value
    input  logic                          s_tuser,   // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fs_pkg::M_TDATA_W-1:0]  m_tdata,   // position
    output logic                          m_tuser,   // found
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fs_pkg::LEN_W-1:0]      cfg_data   // used_length
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam int SW = NW + 3;
    localparam int EW = ELEMENT_WIDTH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIB   = 3'd1;
    localparam logic [2:0] ST_PROBE = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_LAST  = 3'd4;
    localparam logic [2:0] ST_LCMP  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic [fs_pkg::LEN_W-1:0]   used_length_reg;
    logic [NW-1:0]              n_reg, n_next;
    logic signed [EW-1:0]       target_reg, target_next;
    logic signed [SW-1:0]       f0_reg, f0_next;
    logic signed [SW-1:0]       f1_reg, f1_next;
    logic signed [SW-1:0]       f2_reg, f2_next;
    logic signed [SW-1:0]       offset_reg, offset_next;
    logic [AW-1:0]              probe_reg, probe_next;
    logic                       res_found_reg, res_found_next;
    logic [AW-1:0]              res_pos_reg, res_pos_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       m_found_reg, m_found_next;
    logic [fs_pkg::POS_W-1:0]   m_pos_reg, m_pos_next;

    logic [fs_pkg::SLOT_W-1:0]  in_slot;
    logic [fs_pkg::VALUE_W-1:0] in_value;
    logic signed [EW-1:0]       elem_in;
    logic                       slot_ok;
    logic [NW-1:0]              len_sat;
    logic signed [SW-1:0]       n_s;
    logic signed [SW-1:0]       probe_sum;
    logic signed [SW-1:0]       probe_clamp;
    logic signed [SW-1:0]       last_sum;
    logic signed [SW-1:0]       probe_s;
    logic                       we;
    logic [AW-1:0]              rd_addr;
    logic [EW-1:0]              rd_data;
    logic                       cmp_lt;
    logic                       cmp_eq;

    assign in_slot  = s_tdata[fs_pkg::SLOT_W-1:0];
    assign in_value = s_tdata[fs_pkg::SLOT_W +: fs_pkg::VALUE_W];

    generate
        if (EW <= fs_pkg::VALUE_W)
        begin : g_narrow
            assign elem_in = $signed(in_value[EW-1:0]);
        end
        else
        begin : g_wide
            assign elem_in = $signed({{(EW - fs_pkg::VALUE_W){1'b0}}, in_value});
        end
    endgenerate

    assign slot_ok  = (32'(in_slot) < DEPTH);
    assign len_sat  = (32'(used_length_reg) > DEPTH) ? NW'(DEPTH) : NW'(used_length_reg);
    assign n_s      = $signed(SW'(n_reg));
    assign probe_s  = $signed(SW'(probe_reg));

    assign probe_sum = offset_reg + f2_reg;
    assign last_sum  = offset_reg + SW'(1);

    always_comb
    begin
        probe_clamp = probe_sum;
        if (probe_clamp > n_s - SW'(1))
        begin
            probe_clamp = n_s - SW'(1);
        end
        if (probe_clamp < 0)
        begin
            probe_clamp = '0;
        end
    end

    // shared compare unit
    assign cmp_lt = $signed(rd_data) < target_reg;
    assign cmp_eq = (rd_data == target_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_found_reg;
    assign m_tdata   = fs_pkg::M_TDATA_W'(m_pos_reg);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        target_next    = target_reg;
        f0_next        = f0_reg;
        f1_next        = f1_reg;
        f2_next        = f2_reg;
        offset_next    = offset_reg;
        probe_next     = probe_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_found_next   = m_found_reg;
        m_pos_next     = m_pos_reg;
        we             = 1'b0;
        rd_addr        = probe_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == fs_pkg::OP_WRITE)
                    begin
                        we = slot_ok;
                    end
                    else
                    begin
                        n_next         = len_sat;
                        target_next    = elem_in;
                        f0_next        = SW'(1);
                        f1_next        = SW'(1);
                        f2_next        = '0;
                        offset_next    = -SW'(1);
                        res_found_next = 1'b0;
                        res_pos_next   = '0;
                        state_next     = (len_sat == '0) ? ST_DONE : ST_FIB;
                    end
                end
            end
            ST_FIB:
            begin
                if (f0_reg < n_s)
                begin
                    f2_next = f1_reg;
                    f1_next = f0_reg;
                    f0_next = f0_reg + f1_reg;
                end
                else
                begin
                    state_next = (f0_reg > SW'(1)) ? ST_PROBE : ST_LAST;
                end
            end
            ST_PROBE:
            begin
                probe_next = probe_clamp[AW-1:0];
                rd_addr    = probe_clamp[AW-1:0];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (cmp_eq)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = probe_reg;
                    state_next     = ST_DONE;
                end
                else if (cmp_lt)
                begin
                    f0_next     = f1_reg;
                    f1_next     = f2_reg;
                    f2_next     = f1_reg - f2_reg;
                    offset_next = probe_s;
                    state_next  = (f1_reg > SW'(1)) ? ST_PROBE : ST_LAST;
                end
                else
                begin
                    f0_next    = f2_reg;
                    f1_next    = f1_reg - f2_reg;
                    f2_next    = f2_reg - (f1_reg - f2_reg);
                    state_next = (f2_reg > SW'(1)) ? ST_PROBE : ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (f1_reg > 0 && last_sum >= 0 && last_sum < n_s)
                begin
                    probe_next = last_sum[AW-1:0];
                    rd_addr    = last_sum[AW-1:0];
                    state_next = ST_LCMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LCMP:
            begin
                if (cmp_eq)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = probe_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_pos_next   = fs_pkg::POS_W'(res_pos_reg);
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            used_length_reg <= fs_pkg::LEN_RESET;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                used_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        target_reg    <= target_next;
        f0_reg        <= f0_next;
        f1_reg        <= f1_next;
        f2_reg        <= f2_next;
        offset_reg    <= offset_next;
        probe_reg     <= probe_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
    end

    fs_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .wr_addr (AW'(in_slot)),
        .wr_data (elem_in),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == fs_pkg::OP_SEARCH) |=> !s_tready)
        else $error("search item did not make the block busy");

    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("not-found result with nonzero position");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP || state_reg == ST_LCMP) |-> (NW'(probe_reg) < n_reg))
        else $error("probe outside used length");

    a_fib_covers: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_FIB && state_reg == ST_PROBE) |-> (f0_reg >= n_s))
        else $error("Fibonacci range below used length");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_valid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

endmodule

FILE: bench/fs_search_checker.sv
// fs_search_checker: watches the item, result and length channels of the
// Fibonacci search block, predicts each search result and compares it.
// Depends on fs_pkg.
`timescale 1ns / 1ps

module fs_search_checker #(
    parameter int DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [fs_pkg::S_TDATA_W-1:0]  s_tdata,   // slot, value
    input  logic                          s_tuser,   // op
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [fs_pkg::M_TDATA_W-1:0]  m_tdata,   // position
    input  logic                          m_tuser,   // found
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [fs_pkg::LEN_W-1:0]      cfg_data,  // used_length
    output int                            mismatches,
    output int                            pending
);

    typedef struct packed {
        logic                     found;
        logic [fs_pkg::POS_W-1:0] position;
    } lookup_t;

    logic signed [fs_pkg::VALUE_W-1:0] store [DEPTH];
    logic [fs_pkg::LEN_W-1:0]          used_len = fs_pkg::LEN_RESET;
    lookup_t                           lookups_due [$];
    lookup_t                           want;

    task automatic flag_mismatch(input string what, input int got, input int exp_val);
        $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, exp_val);
        mismatches++;
    endtask

    function automatic lookup_t predict_lookup(input logic signed [fs_pkg::VALUE_W-1:0] target);
        lookup_t r;
        int n;
        int fib_m;
        int fib_m1;
        int fib_m2;
        int base;
        int idx;
        r = '0;
        n = int'(used_len);
        if (n > DEPTH)
            n = DEPTH;
        if (n == 0)
            return r;
        fib_m2 = 0;
        fib_m1 = 1;
        fib_m  = 1;
        while (fib_m < n)
        begin
            fib_m2 = fib_m1;
            fib_m1 = fib_m;
            fib_m  = fib_m1 + fib_m2;
        end
        base = -1;
        while (fib_m > 1)
        begin
            idx = base + fib_m2;
            if (idx > n - 1)
                idx = n - 1;
            if (idx < 0)
                idx = 0;
            if (store[idx] < target)
            begin
                fib_m  = fib_m1;
                fib_m1 = fib_m2;
                fib_m2 = fib_m - fib_m1;
                base   = idx;
            end
            else if (store[idx] > target)
            begin
                fib_m  = fib_m2;
                fib_m1 = fib_m1 - fib_m2;
                fib_m2 = fib_m - fib_m1;
            end
            else
            begin
                r.found    = 1'b1;
                r.position = idx[fs_pkg::POS_W-1:0];
                return r;
            end
        end
        // final compare one past the offset, skipped past the end
        idx = base + 1;
        if (fib_m1 > 0 && idx >= 0 && idx < n)
        begin
            if (store[idx] == target)
            begin
                r.found    = 1'b1;
                r.position = idx[fs_pkg::POS_W-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_len = fs_pkg::LEN_RESET;
            lookups_due.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                used_len = cfg_data;
            if (m_tvalid && m_tready)
            begin
                if (lookups_due.size() == 0)
                    flag_mismatch("result with none pending, position", int'(m_tdata), -1);
                else
                begin
                    want = lookups_due.pop_front();
                    if (m_tuser !== want.found)
                        flag_mismatch("found", int'(m_tuser), int'(want.found));
                    if (m_tdata[fs_pkg::POS_W-1:0] !== want.position)
                        flag_mismatch("position", int'(m_tdata[fs_pkg::POS_W-1:0]),
                                      int'(want.position));
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == fs_pkg::OP_WRITE)
                    store[s_tdata[fs_pkg::SLOT_W-1:0]] =
                        s_tdata[fs_pkg::SLOT_W +: fs_pkg::VALUE_W];
                else
                    lookups_due.push_back(
                        predict_lookup(s_tdata[fs_pkg::SLOT_W +: fs_pkg::VALUE_W]));
            end
            pending = lookups_due.size();
        end
    end

endmodule

FILE: bench/tb_fibonacci_search.sv
// tb_fibonacci_search: loads sorted stores, sets lengths and drives searches
// under varied stalls; fs_search_checker judges the results.
// Depends on fs_pkg, fibonacci_search and fs_search_checker.
`timescale 1ns / 1ps

module tb_fibonacci_search;

    localparam int DEPTH       = 1024;
    localparam int DRAIN       = 80;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 12;
    localparam int SQUEEZE     = 5;
    localparam int INT_MIN     = 32'sh8000_0000;
    localparam int INT_MAX     = 32'sh7fff_ffff;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [fs_pkg::S_TDATA_W-1:0]  s_tdata   = '0;   // slot, value
    logic                          s_tuser   = fs_pkg::OP_WRITE;   // op
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [fs_pkg::M_TDATA_W-1:0]  m_tdata;          // position
    logic                          m_tuser;          // found
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [fs_pkg::LEN_W-1:0]      cfg_data  = '0;   // used_length

    int mismatches;
    int pending;
    int send_idle = 0;
    int stall_pct = 0;
    bit hold_req  = 0;
    bit hold_done = 0;
    int quiet     = 0;
    int shadow [DEPTH];
    int phase_len [PHASES] = '{1024, 5, 17, 2047, 33, 2, 0, 700,
                               9, 64, 1, 3, 1024, 47, 128, 12};

    always #2 clk = ~clk;

    fibonacci_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    fs_search_checker #(.DEPTH(DEPTH)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("[fibonacci_search] ERROR");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                m_tready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_item(input logic op, input logic [9:0] slot, input int value);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {6'd0, value, slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_slot(input int slot, input int value);
        send_item(fs_pkg::OP_WRITE, slot[9:0], value);
        shadow[slot] = value;
    endtask

    task automatic search_for(input int target);
        send_item(fs_pkg::OP_SEARCH, 10'($urandom_range(0, DEPTH - 1)), target);
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic set_length(input int len);
        settle();
        cfg_data  = len[fs_pkg::LEN_W-1:0];
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ascending values for slots 0..count-1, kept at or below the next entry
    task automatic load_prefix(input int count);
        longint lim;
        longint cur;
        longint step;
        longint v;
        lim = (count < DEPTH) ? longint'(shadow[count]) : longint'(INT_MAX);
        cur = INT_MIN;
        for (int k = 0; k < count; k++)
        begin
            step = (lim - cur) / (count - k + 1);
            v = cur + longint'($urandom_range(0, int'(step)));
            if (count == DEPTH && k == 0)
                v = INT_MIN;
            if (count == DEPTH && k == count - 1)
                v = INT_MAX;
            write_slot(k, int'(v));
            cur = v;
        end
    endtask

    task automatic keep_sorted_write();
        int     slot;
        longint lo;
        longint hi;
        slot = $urandom_range(0, DEPTH - 1);
        lo = (slot > 0) ? longint'(shadow[slot - 1]) : longint'(INT_MIN);
        hi = (slot < DEPTH - 1) ? longint'(shadow[slot + 1]) : longint'(INT_MAX);
        if (hi < lo)
            write_slot(slot, $urandom);
        else
            write_slot(slot, int'(lo + longint'($urandom_range(0, int'(hi - lo)))));
    endtask

    function automatic int pick_target(input int n);
        int r;
        int idx;
        r   = $urandom_range(0, 9);
        idx = (n > 0) ? $urandom_range(0, n - 1) : 0;
        if (r <= 5)
            return shadow[idx];
        if (r == 6)
            return $urandom_range(0, 1) ? shadow[idx] + 1 : shadow[idx] - 1;
        if (r == 7)
            return $urandom;
        if (r == 8)
            return $urandom_range(0, 1) ? INT_MAX : INT_MIN;
        return shadow[$urandom_range(0, DEPTH - 1)];
    endfunction

    initial
    begin
        int n;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset length of one
        write_slot(0, 5);
        search_for(5);
        search_for(4);
        search_for(6);
        // zero length
        set_length(0);
        search_for(5);
        // unsorted store
        write_slot(0, 9);
        write_slot(1, 3);
        write_slot(2, 7);
        write_slot(3, 1);
        set_length(4);
        search_for(3);
        search_for(7);
        search_for(1);
        search_for(9);
        search_for(2);
        // full store, then a length past the depth
        load_prefix(DEPTH);
        set_length(DEPTH);
        search_for(INT_MIN);
        search_for(INT_MAX);
        search_for(shadow[511]);
        search_for(shadow[1022] + 1);
        set_length(2047);
        search_for(shadow[DEPTH - 1]);
        search_for(shadow[0]);

        for (int p = 0; p < PHASES; p++)
        begin
            n = (phase_len[p] > DEPTH) ? DEPTH : phase_len[p];
            case (p % 4)
                0: begin send_idle = 0;  stall_pct = 0;  end
                1: begin send_idle = 50; stall_pct = 0;  end
                2: begin send_idle = 0;  stall_pct = 50; end
                default: begin send_idle = 29; stall_pct = 29; end
            endcase
            set_length(phase_len[p]);
            if (n > 0 && n <= 16)
                load_prefix(n);
            if (p == SQUEEZE)
            begin
                send_idle = 0;
                stall_pct = 0;
                hold_req  = 1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    if (n < DEPTH && $urandom_range(0, 4) == 0)
                        write_slot($urandom_range(n, DEPTH - 1), $urandom);
                    else
                        keep_sorted_write();
                end
                else
                    search_for(pick_target(n));
            end
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("[fibonacci_search] OK");
        else
            $display("[fibonacci_search] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/fs_pkg.sv
rtl/fs_ram.sv
rtl/fibonacci_search.sv
bench/fs_search_checker.sv
bench/tb_fibonacci_search.sv
